/* rtl/epoch_seconds_to_calendar_assert.svh */
// Assertion macros for the checker file of this block.
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define ESTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("estc assertion failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define ESTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("estc assertion failed");

`endif

/* rtl/estc_pkg.sv */
package estc_pkg;

    localparam logic [31:0] Y2K_UNIX_SECONDS = 32'd946684800;
    localparam int          CYCLE_DAYS       = 1461;
    localparam logic [11:0] BASE_YEAR        = 12'd2000;
    localparam logic [15:0] FIRST_WEEKDAY    = 16'd5;
    localparam int          NUM_STAGES       = 11;

    typedef logic [1:0]  year_idx_t;
    typedef logic [3:0]  month_idx_t;
    typedef logic [10:0] cycle_day_t;

    typedef struct packed {
        logic mul;
        logic fix;
    } cdiv_load_t;

    localparam cycle_day_t MONTH_START [4][12] = '{
        '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
          11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
        '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
          11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
        '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
          11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
        '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
          11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
    };

endpackage

/* rtl/estc_cdiv.sv */
module estc_cdiv #(
    parameter int IN_W    = 32,
    parameter int DIVISOR = 60,
    parameter int Q_W     = 26,
    parameter int R_W     = 6
) (
    input  logic                clk,
    input  estc_pkg::cdiv_load_t load,
    input  logic [IN_W-1:0]     dividend,
    output logic [Q_W-1:0]      quotient,
    output logic [R_W-1:0]      remainder
);
    import estc_pkg::*;

    localparam int SHIFT = IN_W + $clog2(DIVISOR) - 1;
    localparam int PW    = 2 * IN_W + 1;
    localparam logic [IN_W:0]   MULT  = (IN_W + 1)'(((64'd1 << SHIFT) / DIVISOR));
    localparam logic [IN_W-1:0] DIV_C = IN_W'(DIVISOR);

    logic [PW-1:0]   prod;
    logic [Q_W-1:0]  est_reg;
    logic [IN_W-1:0] num_reg;
    logic [IN_W-1:0] rem_raw;
    logic [Q_W-1:0]  quo_next;
    logic [IN_W-1:0] rem_next;
    logic [Q_W-1:0]  quo_reg;
    logic [R_W-1:0]  rem_reg;

    // The reciprocal estimate is at most one below the true quotient.
    assign prod = PW'(dividend) * PW'(MULT);

    always_comb
    begin
        rem_raw = num_reg - IN_W'(est_reg) * DIV_C;
        if (rem_raw >= DIV_C)
        begin
            quo_next = est_reg + Q_W'(1);
            rem_next = rem_raw - DIV_C;
        end
        else
        begin
            quo_next = est_reg;
            rem_next = rem_raw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.mul)
        begin
            est_reg <= prod[SHIFT +: Q_W];
            num_reg <= dividend;
        end
        if (load.fix)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next[R_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/epoch_seconds_to_calendar.sv */
// An input transfer is registered, passes the divisions, then the year and month stages.
// Throughput: one transfer per cycle while the output is not stalled; each of the five
// constant divisions takes two stages (reciprocal multiply, then a single correction step).
// A stalled output holds only the stages that are full; empty stages keep filling.
// Reset clears the stage valid bits only; data registers are not reset.
module epoch_seconds_to_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seconds_valid,
    output logic        seconds_stall,
    input  logic [31:0] unix_seconds,
    output logic        calendar_valid,
    input  logic        calendar_stall,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [8:0]  day_of_year,
    output logic [2:0]  weekday,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);
    import estc_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] advance;

    logic [31:0] t_next;
    logic [31:0] t_reg;

    logic [25:0] a_quo;
    logic [5:0]  a_rem;
    logic [19:0] b_quo;
    logic [5:0]  b_rem;
    logic [15:0] c_quo;
    logic [4:0]  c_rem;
    logic [4:0]  d_quo;
    logic [10:0] d_rem;
    logic [2:0]  e_rem;
    logic [15:0] wday_dividend;

    logic [5:0] sec_pipe_reg  [3:9];
    logic [5:0] min_pipe_reg  [5:9];
    logic [4:0] hour_pipe_reg [7:9];

    year_idx_t  yi_next;
    year_idx_t  yi_reg;
    cycle_day_t dcyc_reg;
    logic [11:0] year_next;
    logic [8:0]  yday_next;
    logic [11:0] year9_reg;
    logic [8:0]  yday9_reg;
    logic [2:0]  wday9_reg;

    month_idx_t mi_next;
    logic [3:0] month_next;
    logic [4:0] mday_next;

    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  mday_reg;
    logic [8:0]  yday_reg;
    logic [2:0]  wday_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  min_reg;
    logic [5:0]  sec_reg;

    always_comb
    begin
        advance[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !calendar_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            advance[k] = !valid_reg[k] || advance[k+1];
        end
    end

    assign seconds_stall  = !advance[0];
    assign calendar_valid = valid_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (advance[0])
            begin
                valid_reg[0] <= seconds_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (advance[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Times before 2000 collapse to zero, which decodes to 2000-01-01 00:00:00.
    assign t_next = (unix_seconds >= Y2K_UNIX_SECONDS) ? unix_seconds - Y2K_UNIX_SECONDS : '0;

    always_ff @(posedge clk)
    begin
        if (advance[0])
        begin
            t_reg <= t_next;
        end
    end

    estc_cdiv #(.IN_W(32), .DIVISOR(60), .Q_W(26), .R_W(6)) u_div_sec (
        .clk       (clk),
        .load      ('{mul: advance[1], fix: advance[2]}),
        .dividend  (t_reg),
        .quotient  (a_quo),
        .remainder (a_rem)
    );

    estc_cdiv #(.IN_W(26), .DIVISOR(60), .Q_W(20), .R_W(6)) u_div_min (
        .clk       (clk),
        .load      ('{mul: advance[3], fix: advance[4]}),
        .dividend  (a_quo),
        .quotient  (b_quo),
        .remainder (b_rem)
    );

    estc_cdiv #(.IN_W(20), .DIVISOR(24), .Q_W(16), .R_W(5)) u_div_hour (
        .clk       (clk),
        .load      ('{mul: advance[5], fix: advance[6]}),
        .dividend  (b_quo),
        .quotient  (c_quo),
        .remainder (c_rem)
    );

    estc_cdiv #(.IN_W(16), .DIVISOR(CYCLE_DAYS), .Q_W(5), .R_W(11)) u_div_cycle (
        .clk       (clk),
        .load      ('{mul: advance[7], fix: advance[8]}),
        .dividend  (c_quo),
        .quotient  (d_quo),
        .remainder (d_rem)
    );

    assign wday_dividend = c_quo + FIRST_WEEKDAY;

    estc_cdiv #(.IN_W(16), .DIVISOR(7), .Q_W(13), .R_W(3)) u_div_week (
        .clk       (clk),
        .load      ('{mul: advance[7], fix: advance[8]}),
        .dividend  (wday_dividend),
        .quotient  (),
        .remainder (e_rem)
    );

    always_ff @(posedge clk)
    begin
        if (advance[3])
        begin
            sec_pipe_reg[3] <= a_rem;
        end
        for (int k = 4; k <= 9; k++)
        begin
            if (advance[k])
            begin
                sec_pipe_reg[k] <= sec_pipe_reg[k-1];
            end
        end
        if (advance[5])
        begin
            min_pipe_reg[5] <= b_rem;
        end
        for (int k = 6; k <= 9; k++)
        begin
            if (advance[k])
            begin
                min_pipe_reg[k] <= min_pipe_reg[k-1];
            end
        end
        if (advance[7])
        begin
            hour_pipe_reg[7] <= c_rem;
        end
        for (int k = 8; k <= 9; k++)
        begin
            if (advance[k])
            begin
                hour_pipe_reg[k] <= hour_pipe_reg[k-1];
            end
        end
    end

    always_comb
    begin
        if (d_rem >= MONTH_START[3][0])
        begin
            yi_next = 2'd3;
        end
        else if (d_rem >= MONTH_START[2][0])
        begin
            yi_next = 2'd2;
        end
        else if (d_rem >= MONTH_START[1][0])
        begin
            yi_next = 2'd1;
        end
        else
        begin
            yi_next = 2'd0;
        end
        yday_next = 9'(d_rem - MONTH_START[yi_next][0]);
        year_next = BASE_YEAR + {5'd0, d_quo, 2'b00} + {10'd0, yi_next};
    end

    always_ff @(posedge clk)
    begin
        if (advance[9])
        begin
            yi_reg    <= yi_next;
            dcyc_reg  <= d_rem;
            year9_reg <= year_next;
            yday9_reg <= yday_next;
            wday9_reg <= e_rem;
        end
    end

    always_comb
    begin
        mi_next = '0;
        for (int m = 1; m < 12; m++)
        begin
            if (dcyc_reg >= MONTH_START[yi_reg][m])
            begin
                mi_next = 4'(m);
            end
        end
        month_next = mi_next + 4'd1;
        mday_next  = 5'(dcyc_reg - MONTH_START[yi_reg][mi_next] + 11'd1);
    end

    always_ff @(posedge clk)
    begin
        if (advance[10])
        begin
            year_reg  <= year9_reg;
            month_reg <= month_next;
            mday_reg  <= mday_next;
            yday_reg  <= yday9_reg;
            wday_reg  <= wday9_reg;
            hour_reg  <= hour_pipe_reg[9];
            min_reg   <= min_pipe_reg[9];
            sec_reg   <= sec_pipe_reg[9];
        end
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = mday_reg;
    assign day_of_year  = yday_reg;
    assign weekday      = wday_reg;
    assign hour         = hour_reg;
    assign minute       = min_reg;
    assign second       = sec_reg;

endmodule

/* rtl/estc_checker.sv */
`include "epoch_seconds_to_calendar_assert.svh"

module estc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        seconds_valid,
    input logic        seconds_stall,
    input logic [31:0] unix_seconds,
    input logic        calendar_valid,
    input logic        calendar_stall,
    input logic [11:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day_of_month,
    input logic [8:0]  day_of_year,
    input logic [2:0]  weekday,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second
);

    `ESTC_ASSERT_NOW(a_date_range, calendar_valid, month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1 && weekday <= 3'd6)

    `ESTC_ASSERT_NOW(a_time_range, calendar_valid, hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)

    `ESTC_ASSERT_NOW(a_year_range, calendar_valid, year >= 12'd2000 && year <= 12'd2106 && day_of_year <= 9'd365)

    `ESTC_ASSERT_NEXT(a_out_hold, calendar_valid && calendar_stall, calendar_valid && $stable(year) && $stable(day_of_year) && $stable(second))

    `ESTC_ASSERT_NEXT(a_in_hold, seconds_valid && seconds_stall, seconds_valid && $stable(unix_seconds))

endmodule

bind epoch_seconds_to_calendar estc_checker u_estc_checker (.*);

/* tb/tb.sv */
module tb;

    localparam logic [31:0] SECONDS_AT_2000 = 32'd946684800;
    localparam int unsigned DAYS_PER_CYCLE  = 1461;
    localparam int unsigned SATURDAY        = 5;
    localparam int          HOLD_OFF_CYCLES = 90;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [8:0]  day_of_year;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } calendar_t;

    typedef struct {
        logic [31:0] seconds;
        int          idle_pct;
        int          stall_pct;
        bit          hold_off;
        bit          wait_empty;
    } offer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        seconds_valid = 1'b0;
    logic        seconds_stall;
    logic [31:0] unix_seconds = 32'd0;
    logic        calendar_valid;
    logic        calendar_stall = 1'b0;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [8:0]  day_of_year;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    offer_t    offer_q[$];
    calendar_t expected_calendar_q[$];
    int        total_offers = 0;
    int        accepted_count = 0;
    int        mismatch_count = 0;
    int        stall_pct = 0;
    bit        hold_kick = 1'b0;
    int        hold_left = 0;

    epoch_seconds_to_calendar u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .seconds_valid  (seconds_valid),
        .seconds_stall  (seconds_stall),
        .unix_seconds   (unix_seconds),
        .calendar_valid (calendar_valid),
        .calendar_stall (calendar_stall),
        .year           (year),
        .month          (month),
        .day_of_month   (day_of_month),
        .day_of_year    (day_of_year),
        .weekday        (weekday),
        .hour           (hour),
        .minute         (minute),
        .second         (second)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic calendar_t calendar_of(input logic [31:0] secs);
        calendar_t   c;
        int unsigned t;
        int unsigned days;
        int unsigned cycle_day;
        int unsigned year_in_cycle;
        int unsigned m;
        int unsigned len;
        bit          leap;
        bit          found;
        c.year         = 12'd2000;
        c.month        = 4'd1;
        c.day_of_month = 5'd1;
        c.day_of_year  = 9'd0;
        c.weekday      = 3'(SATURDAY);
        c.hour         = 5'd0;
        c.minute       = 6'd0;
        c.second       = 6'd0;
        if (secs >= SECONDS_AT_2000)
        begin
            t = secs - SECONDS_AT_2000;
            c.second = 6'(t % 60);
            t = t / 60;
            c.minute = 6'(t % 60);
            t = t / 60;
            c.hour = 5'(t % 24);
            days = t / 24;
            c.weekday = 3'((days + SATURDAY) % 7);
            cycle_day = days % DAYS_PER_CYCLE;
            year_in_cycle = (cycle_day < 366) ? 0 : (cycle_day - 1) / 365;
            c.year = 12'(2000 + 4 * (days / DAYS_PER_CYCLE) + year_in_cycle);
            t = (year_in_cycle == 0) ? cycle_day : cycle_day - 365 * year_in_cycle - 1;
            c.day_of_year = 9'(t);
            leap = (year_in_cycle == 0);
            m = 1;
            found = 1'b0;
            while (!found)
            begin
                if (m == 2)
                    len = leap ? 29 : 28;
                else if (m == 4 || m == 6 || m == 9 || m == 11)
                    len = 30;
                else
                    len = 31;
                if (t < len)
                    found = 1'b1;
                else
                begin
                    t = t - len;
                    m = m + 1;
                end
            end
            c.month = 4'(m);
            c.day_of_month = 5'(t + 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] at_day(input int unsigned days, input int unsigned sod);
        longint v;
        v = longint'(SECONDS_AT_2000) + longint'(days) * 86400 + longint'(sod);
        if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF - $urandom_range(86399);
        return v[31:0];
    endfunction

    function automatic int unsigned year_edge_day();
        case ($urandom_range(9))
            0: return 0;
            1: return 58;
            2: return 59;
            3: return 60;
            4: return 365;
            5: return 366;
            6: return 730;
            7: return 731;
            8: return 1095;
            default: return $urandom_range(1) ? 1096 : 1460;
        endcase
    endfunction

    function automatic int unsigned day_edge_second();
        case ($urandom_range(3))
            0: return $urandom_range(59);
            1: return 86399 - $urandom_range(59);
            default: return $urandom_range(86399);
        endcase
    endfunction

    function automatic logic [31:0] random_seconds();
        case ($urandom_range(9))
            0, 1, 2: return $urandom;
            3: return $urandom_range(946684799);
            4: return 32'd946684700 + $urandom_range(200);
            5: return at_day($urandom_range(26) * DAYS_PER_CYCLE + year_edge_day()
                             + $urandom_range(2) - 1 + 1, day_edge_second());
            6: return at_day($urandom_range(26) * DAYS_PER_CYCLE + $urandom_range(1460),
                             day_edge_second());
            7: return 32'hFFFF_FFFF - $urandom_range(200000);
            default: return SECONDS_AT_2000 + $urandom_range(32'hFFFF_FFFF - SECONDS_AT_2000);
        endcase
    endfunction

    task automatic add_offer(input logic [31:0] secs, input int idle, input int stall,
                             input bit hold, input bit wait_empty);
        offer_t o;
        o.seconds    = secs;
        o.idle_pct   = idle;
        o.stall_pct  = stall;
        o.hold_off   = hold;
        o.wait_empty = wait_empty;
        offer_q.push_back(o);
        total_offers = total_offers + 1;
    endtask

    task automatic add_phase(input int count, input int idle, input int stall,
                             input int hold_at, input bit wait_first);
        int i;
        for (i = 0; i < count; i++)
            add_offer(random_seconds(), idle, stall, i == hold_at, wait_first && i == 0);
    endtask

    task automatic report_field(input string name, input int unsigned exp_v,
                                input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatch_count = mismatch_count + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        offer_t head;
        bit     kick;
        if (!rst_n)
        begin
            seconds_valid <= 1'b0;
            unix_seconds  <= 32'd0;
            hold_kick     <= 1'b0;
            stall_pct     <= 0;
        end
        else
        begin
            kick = 1'b0;
            if (seconds_valid && !seconds_stall)
            begin
                expected_calendar_q.push_back(calendar_of(unix_seconds));
                accepted_count = accepted_count + 1;
            end
            if (!seconds_valid || !seconds_stall)
            begin
                if (offer_q.size() != 0
                    && !(offer_q[0].wait_empty && expected_calendar_q.size() != 0)
                    && $urandom_range(99) >= offer_q[0].idle_pct)
                begin
                    head = offer_q.pop_front();
                    seconds_valid <= 1'b1;
                    unix_seconds  <= head.seconds;
                    stall_pct     <= head.stall_pct;
                    kick = head.hold_off;
                end
                else
                    seconds_valid <= 1'b0;
            end
            hold_kick <= kick;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calendar_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_kick)
                hold_left = HOLD_OFF_CYCLES;
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                calendar_stall <= 1'b1;
            end
            else
                calendar_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : monitor
        calendar_t exp_c;
        if (rst_n && calendar_valid && !calendar_stall)
        begin
            if (expected_calendar_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual %0d-%0d-%0d",
                         $time, year, month, day_of_month);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                exp_c = expected_calendar_q.pop_front();
                report_field("year", exp_c.year, year);
                report_field("month", exp_c.month, month);
                report_field("day_of_month", exp_c.day_of_month, day_of_month);
                report_field("day_of_year", exp_c.day_of_year, day_of_year);
                report_field("weekday", exp_c.weekday, weekday);
                report_field("hour", exp_c.hour, hour);
                report_field("minute", exp_c.minute, minute);
                report_field("second", exp_c.second, second);
            end
        end
    end

    initial
    begin
        add_offer(32'd0, 0, 0, 0, 0);
        add_offer(32'd946684799, 0, 0, 0, 0);
        add_offer(32'd946684800, 0, 0, 0, 0);
        add_offer(32'd946684801, 0, 0, 0, 0);
        add_offer(at_day(0, 86399), 0, 0, 0, 0);
        add_offer(at_day(58, 43200), 0, 0, 0, 0);
        add_offer(at_day(59, 0), 0, 0, 0, 0);
        add_offer(at_day(60, 0), 0, 0, 0, 0);
        add_offer(at_day(365, 86399), 0, 0, 0, 0);
        add_offer(at_day(366, 0), 0, 0, 0, 0);
        add_offer(at_day(424, 3600), 0, 0, 0, 0);
        add_offer(at_day(1460, 86399), 0, 0, 0, 0);
        add_offer(at_day(1461, 0), 0, 0, 0, 0);
        add_offer(at_day(25 * 1461 + 58, 86399), 0, 0, 0, 0);
        add_offer(at_day(25 * 1461 + 59, 0), 0, 0, 0, 0);
        add_offer(at_day(25 * 1461 + 60, 0), 0, 0, 0, 0);
        add_offer(at_day(25 * 1461 + 365, 0), 0, 0, 0, 0);
        add_offer(32'h8000_0000, 0, 0, 0, 0);
        add_offer(32'hAAAA_AAAA, 0, 0, 0, 0);
        add_offer(32'h5555_5555, 0, 0, 0, 0);
        add_offer(32'hFFFF_FFFE, 0, 0, 0, 0);
        add_offer(32'hFFFF_FFFF, 0, 0, 0, 0);
        add_phase(170, 0, 0, 40, 1'b0);
        add_phase(160, 82, 0, -1, 1'b1);
        add_phase(160, 0, 82, -1, 1'b1);
        add_phase(160, 31, 31, 60, 1'b0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count != total_offers)
            @(posedge clk);
        while (expected_calendar_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
